[rtl/core/soc_pkg.sv]
package soc_pkg;

    localparam int MAX_OBSTACLES = 64;
    localparam int COORD_BITS    = 12;
    localparam int CFG_W         = 7;
    localparam int SLOT_W        = 6;
    localparam int ADDR_W        = $clog2(MAX_OBSTACLES);
    localparam int K_W           = $clog2(MAX_OBSTACLES + 1);
    localparam int DIFF_W        = COORD_BITS + 1;
    localparam int PROD_W        = 2 * DIFF_W;

    // one segment, also one table entry
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } t_seg;

    typedef enum logic [1:0] {
        OR_COL = 2'd0,
        OR_CW  = 2'd1,
        OR_CCW = 2'd2
    } t_orient;

    // orientation request: sign of turn p -> q -> r, plus r inside box of p and q
    typedef struct packed {
        logic                         valid;
        logic [1:0]                   tag;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] qx;
        logic signed [COORD_BITS-1:0] qy;
        logic signed [COORD_BITS-1:0] rx;
        logic signed [COORD_BITS-1:0] ry;
    } t_orient_req;

    typedef struct packed {
        logic       valid;
        logic [1:0] tag;
        t_orient    code;
        logic       on_seg;
    } t_orient_rsp;

endpackage

[rtl/core/soc_table.sv]
module soc_table (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [soc_pkg::ADDR_W-1:0]   i_waddr,
    input  soc_pkg::t_seg                i_wdata,
    input  logic                         i_re,
    input  logic [soc_pkg::ADDR_W-1:0]   i_raddr,
    output soc_pkg::t_seg                o_rdata
);

    soc_pkg::t_seg r_mem [soc_pkg::MAX_OBSTACLES];
    soc_pkg::t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/soc_orient.sv]
module soc_orient (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  soc_pkg::t_orient_req i_req,
    output soc_pkg::t_orient_rsp o_rsp
);

    localparam int DW = soc_pkg::DIFF_W;
    localparam int PW = soc_pkg::PROD_W;
    localparam int CB = soc_pkg::COORD_BITS;

    logic signed [DW-1:0] d1, d2, d3, d4;
    logic signed [PW-1:0] m1, m2;
    logic                 in_x, in_y;

    logic signed [PW-1:0] r_m1, r_m2;
    logic                 r_inbox;
    logic [1:0]           r_tag;
    logic                 r_vld1;

    logic [PW:0]          v;
    soc_pkg::t_orient     code;

    logic                 r_vld2;
    logic [1:0]           r_tag2;
    soc_pkg::t_orient     r_code2;
    logic                 r_on2;

    // stage 1: differences and the two products
    assign d1 = {i_req.qy[CB-1], i_req.qy} - {i_req.py[CB-1], i_req.py};
    assign d2 = {i_req.rx[CB-1], i_req.rx} - {i_req.qx[CB-1], i_req.qx};
    assign d3 = {i_req.qx[CB-1], i_req.qx} - {i_req.px[CB-1], i_req.px};
    assign d4 = {i_req.ry[CB-1], i_req.ry} - {i_req.qy[CB-1], i_req.qy};
    assign m1 = d1 * d2;
    assign m2 = d3 * d4;

    assign in_x = ($signed(i_req.px) <= $signed(i_req.rx) &&
                   $signed(i_req.rx) <= $signed(i_req.qx)) ||
                  ($signed(i_req.qx) <= $signed(i_req.rx) &&
                   $signed(i_req.rx) <= $signed(i_req.px));
    assign in_y = ($signed(i_req.py) <= $signed(i_req.ry) &&
                   $signed(i_req.ry) <= $signed(i_req.qy)) ||
                  ($signed(i_req.qy) <= $signed(i_req.ry) &&
                   $signed(i_req.ry) <= $signed(i_req.py));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1    <= m1;
        r_m2    <= m2;
        r_inbox <= in_x && in_y;
        r_tag   <= i_req.tag;
    end

    // stage 2: subtract and take the sign
    assign v = {r_m1[PW-1], r_m1} - {r_m2[PW-1], r_m2};

    always_comb begin
        if (v == '0) begin
            code = soc_pkg::OR_COL;
        end else if (v[PW]) begin
            code = soc_pkg::OR_CCW;
        end else begin
            code = soc_pkg::OR_CW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag2  <= r_tag;
        r_code2 <= code;
        r_on2   <= r_inbox && (v == '0);
    end

    assign o_rsp = '{valid: r_vld2, tag: r_tag2, code: r_code2, on_seg: r_on2};

    a_rsp_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> $past(i_req.valid, 2))
        else $error("orientation result without a request two cycles before");

endmodule

[rtl/core/segment_obstacle_collision_check.sv]
// load word: written into the wall table in the cycle it is accepted, ready again next cycle
// query word: walls 0 .. n-1 are checked in order until the first hit, n = min(obstacle_count, 64)
// (no walls: answered free straight from idle); each wall uses the one shared orientation unit
// (four orientation tests issued back to back, then the drain of its pipeline)
// the next word is taken only after a query's flag has gone to the result register, once that is free
// synchronous active-low reset clears the sequencer, the count and o_out_valid, not the table
module segment_obstacle_collision_check (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [soc_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_mode,
    input  logic [soc_pkg::SLOT_W-1:0]           i_slot,
    input  logic signed [soc_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [soc_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [soc_pkg::COORD_BITS-1:0] i_end_x,
    input  logic signed [soc_pkg::COORD_BITS-1:0] i_end_y,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_path_free
);

    localparam int AW = soc_pkg::ADDR_W;
    localparam int KW = soc_pkg::K_W;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,   // fetch wall 0
        S_OP   = 5'b00100,   // issue the four orientation tests
        S_WAIT = 5'b01000,   // drain the unit, judge the wall on the last result
        S_DONE = 5'b10000    // hand the flag to the result register
    } t_state;

    t_state                 r_state;
    logic [soc_pkg::CFG_W-1:0] r_count;
    logic [KW-1:0]          r_k;
    logic [1:0]             r_op;
    soc_pkg::t_orient       r_code [3];     // o1..o3, o4 is taken straight off the unit
    logic                   r_on_any;
    logic                   r_result;
    soc_pkg::t_seg          r_q;            // query segment
    logic                   r_out_valid;
    logic                   r_path_free;

    logic                   in_acc;
    logic                   load_we;
    logic [KW-1:0]          n_sat;
    logic [KW-1:0]          kp1;
    logic                   last_rsp;
    logic                   hit;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    soc_pkg::t_seg          wr_seg;
    soc_pkg::t_seg          wall;
    soc_pkg::t_orient_req   req;
    soc_pkg::t_orient_rsp   rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // slots past the table are dropped
    assign load_we = in_acc && !i_mode &&
                     (32'(i_slot) < 32'(soc_pkg::MAX_OBSTACLES));

    assign wr_seg.ax = i_start_x;
    assign wr_seg.ay = i_start_y;
    assign wr_seg.bx = i_end_x;
    assign wr_seg.by = i_end_y;

    // counts above the table depth check the whole table
    assign n_sat = (32'(r_count) > 32'(soc_pkg::MAX_OBSTACLES)) ?
                   KW'(soc_pkg::MAX_OBSTACLES) : KW'(r_count);
    assign kp1   = r_k + KW'(1);

    // next wall is fetched in the judging cycle so it is ready for the first test
    assign rd_en   = (r_state == S_READ) || (r_state == S_WAIT);
    assign rd_addr = (r_state == S_WAIT) ? kp1[AW-1:0] : r_k[AW-1:0];

    soc_table u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (AW'(i_slot)),
        .i_wdata (wr_seg),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (wall)
    );

    // operand steering for the shared unit:
    // tests 0/1 turn the query towards wall ends a/b, tests 2/3 turn the wall
    // towards query ends start/end
    always_comb begin
        req.valid = (r_state == S_OP);
        req.tag   = r_op;
        if (r_op[1]) begin
            req.px = wall.ax;
            req.py = wall.ay;
            req.qx = wall.bx;
            req.qy = wall.by;
            req.rx = r_op[0] ? r_q.bx : r_q.ax;
            req.ry = r_op[0] ? r_q.by : r_q.ay;
        end else begin
            req.px = r_q.ax;
            req.py = r_q.ay;
            req.qx = r_q.bx;
            req.qy = r_q.by;
            req.rx = r_op[0] ? wall.bx : wall.ax;
            req.ry = r_op[0] ? wall.by : wall.ay;
        end
    end

    soc_orient u_orient (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // general crossing, or any collinear touch
    assign last_rsp = rsp.valid && (rsp.tag == 2'd3);
    assign hit = ((r_code[0] != r_code[1]) && (r_code[2] != rsp.code)) ||
                 r_on_any || rsp.on_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    // collinear touches gathered over the first three tests of a wall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_any <= 1'b0;
        end else if ((r_state == S_READ) || last_rsp) begin
            r_on_any <= 1'b0;
        end else if (rsp.valid) begin
            r_on_any <= r_on_any || rsp.on_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_op     <= '0;
            r_result <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode) begin
                        r_k <= '0;
                        if (n_sat == '0) begin
                            r_result <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_op     <= '0;
                    r_state  <= S_OP;
                end
                S_OP: begin
                    r_op <= r_op + 2'd1;
                    if (r_op == 2'd3) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (last_rsp) begin
                        r_op     <= '0;
                        if (hit) begin
                            r_result <= 1'b0;
                            r_state  <= S_DONE;
                        end else if (kp1 == n_sat) begin
                            r_result <= 1'b1;
                            r_state  <= S_DONE;
                        end else begin
                            r_k     <= kp1;
                            r_state <= S_OP;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp.valid && (rsp.tag != 2'd3)) begin
            r_code[rsp.tag] <= rsp.code;
        end
        if (in_acc && i_mode) begin
            r_q <= wr_seg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_path_free <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_path_free = r_path_free;

    a_empty_query_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode && (n_sat == '0)) |=> (r_state == S_DONE) && r_result)
        else $error("query with no walls not answered free at once");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_mode) |=> (r_state == S_IDLE))
        else $error("load word left the idle state");

    a_wall_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OP) || (r_state == S_WAIT)) |-> (r_k < n_sat))
        else $error("wall index beyond checked count");

endmodule

[tb/sv/clearance_tb_pkg.sv]
package clearance_tb_pkg;

    // meaning of the mode bit of an input word
    typedef enum logic {
        WORD_LOAD  = 1'b0,
        WORD_QUERY = 1'b1
    } t_word_kind;

endpackage

[tb/sv/path_clearance_checker.sv]
module path_clearance_checker
    import soc_pkg::*;
    import clearance_tb_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_mode,
    input  logic [SLOT_W-1:0]             i_slot,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_path_free,
    output int unsigned                   o_outstanding,
    output int unsigned                   o_fail_count
);

    typedef struct {
        t_seg path;
        logic free;
    } t_flag_due;

    t_seg             walls [MAX_OBSTACLES];
    logic [CFG_W-1:0] wall_limit;
    t_flag_due        flags_due [$];
    int unsigned      fails = 0;

    // sign of the turn p -> q -> r
    function automatic t_orient turn_sign(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
        longint v;
        v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (v == 0) return OR_COL;
        return (v > 0) ? OR_CW : OR_CCW;
    endfunction

    // q inside the bounding box of p and r
    function automatic bit in_box(longint px, longint py, longint qx, longint qy,
                                  longint rx, longint ry);
        return qx >= ((px < rx) ? px : rx) && qx <= ((px < rx) ? rx : px) &&
               qy >= ((py < ry) ? py : ry) && qy <= ((py < ry) ? ry : py);
    endfunction

    function automatic bit touches(t_seg p, t_seg w);
        longint  pax, pay, pbx, pby, wax, way, wbx, wby;
        t_orient o1, o2, o3, o4;
        pax = $signed(p.ax);
        pay = $signed(p.ay);
        pbx = $signed(p.bx);
        pby = $signed(p.by);
        wax = $signed(w.ax);
        way = $signed(w.ay);
        wbx = $signed(w.bx);
        wby = $signed(w.by);
        o1 = turn_sign(pax, pay, pbx, pby, wax, way);
        o2 = turn_sign(pax, pay, pbx, pby, wbx, wby);
        o3 = turn_sign(wax, way, wbx, wby, pax, pay);
        o4 = turn_sign(wax, way, wbx, wby, pbx, pby);
        if (o1 != o2 && o3 != o4) return 1'b1;
        // collinear with an endpoint lying on the other segment
        if (o1 == OR_COL && in_box(pax, pay, wax, way, pbx, pby)) return 1'b1;
        if (o2 == OR_COL && in_box(pax, pay, wbx, wby, pbx, pby)) return 1'b1;
        if (o3 == OR_COL && in_box(wax, way, pax, pay, wbx, wby)) return 1'b1;
        if (o4 == OR_COL && in_box(wax, way, pbx, pby, wbx, wby)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic clear_of_walls(t_seg p);
        int unsigned n;
        n = (wall_limit > MAX_OBSTACLES) ? MAX_OBSTACLES : wall_limit;
        for (int unsigned k = 0; k < n; k++) begin
            if (touches(p, walls[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_seg      seg;
        t_flag_due oldest;
        t_flag_due fresh;
        seg = '{ax: i_start_x, ay: i_start_y, bx: i_end_x, by: i_end_y};
        if (!i_rst_n) begin
            wall_limit = '0;
            flags_due.delete();
        end else begin
            if (i_cfg_we) wall_limit = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                if (i_mode == WORD_LOAD) begin
                    walls[i_slot] = seg;
                end else begin
                    fresh.path = seg;
                    fresh.free = clear_of_walls(seg);
                    flags_due  = {flags_due, fresh};
                end
            end
            if (i_out_valid === 1'b1 && i_out_ready) begin
                if (flags_due.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word: expected none, actual path_free=%b",
                             $time, i_path_free);
                end else begin
                    oldest = flags_due.pop_front();
                    if (i_path_free !== oldest.free) begin
                        fails++;
                        $display("%0t: path_free for (%0d,%0d)-(%0d,%0d): expected %b, actual %b",
                                 $time, oldest.path.ax, oldest.path.ay, oldest.path.bx,
                                 oldest.path.by, oldest.free, i_path_free);
                    end
                end
            end
        end
        o_outstanding <= flags_due.size();
        o_fail_count  <= fails;
    end

endmodule

[tb/sv/segment_obstacle_collision_check_test.sv]
module segment_obstacle_collision_check_test;
    import soc_pkg::*;
    import clearance_tb_pkg::*;

    // generous bound: every word a full-table query with the longest gaps and stalls, times five
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // a wall write lands in the cycle its word is taken, so this settle wait covers it
    localparam int unsigned LOAD_SETTLE = 4;
    // tail wait: long enough for a query over a full table, with margin
    localparam int unsigned TAIL_CYCLES = 6 * MAX_OBSTACLES + 8;
    localparam int unsigned PHASES      = 11;
    localparam int unsigned PHASE_WORDS = 105;

    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    // how coordinates of a random word are spread
    typedef enum {
        COORD_FULL,
        COORD_GRID,
        COORD_EDGE
    } t_spread;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]             i_cfg_wdata = '0;
    logic                         i_in_valid  = 1'b0;
    logic                         i_mode      = 1'b0;
    logic [SLOT_W-1:0]            i_slot      = '0;
    logic signed [COORD_BITS-1:0] i_start_x   = '0;
    logic signed [COORD_BITS-1:0] i_start_y   = '0;
    logic signed [COORD_BITS-1:0] i_end_x     = '0;
    logic signed [COORD_BITS-1:0] i_end_y     = '0;
    logic                         i_out_ready = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_path_free;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count = 0;
    // set for whole phases with no idling on either side
    bit          calm        = 1'b0;

    segment_obstacle_collision_check uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_slot      (i_slot),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_path_free (o_path_free)
    );

    // predicts path_free for every query word and compares the returned words
    path_clearance_checker flag_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_slot        (i_slot),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_path_free   (o_path_free),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic t_spread pick_spread();
        int unsigned r;
        r = $urandom_range(0, 99);
        // a small grid makes collinear overlaps and shared endpoints common
        if (r < 40) return COORD_GRID;
        if (r < 85) return COORD_FULL;
        return COORD_EDGE;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] pick_coord(t_spread s);
        case (s)
            COORD_GRID: return COORD_BITS'($urandom_range(0, 16) - 8);
            COORD_EDGE: begin
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
        endcase
    endfunction

    // mostly the word's own spread, sometimes a stray coordinate
    function automatic logic signed [COORD_BITS-1:0] coord_like(t_spread s);
        if ($urandom_range(0, 9) == 0) return pick_coord(pick_spread());
        return pick_coord(s);
    endfunction

    // receiver side: ready in runs, with stalls of random length in between
    initial begin : result_sink
        int unsigned run;
        run = 1;
        forever begin
            repeat (run) @(posedge i_clk);
            if (calm || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                run = $urandom_range(1, 24);
            end else begin
                i_out_ready <= 1'b0;
                run = idle_span() + 1;
            end
        end
    end

    // offers one word after an optional gap and returns at the edge it is taken;
    // valid stays high so a following word can go out back to back
    task automatic push_word(input t_word_kind kind, input logic [SLOT_W-1:0] slot,
                             input logic signed [COORD_BITS-1:0] sx,
                             input logic signed [COORD_BITS-1:0] sy,
                             input logic signed [COORD_BITS-1:0] ex,
                             input logic signed [COORD_BITS-1:0] ey);
        int unsigned gap;
        gap = idle_span();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= kind;
        i_slot     <= slot;
        i_start_x  <= sx;
        i_start_y  <= sy;
        i_end_x    <= ex;
        i_end_y    <= ey;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic push_random(input t_word_kind kind);
        t_spread s;
        s = pick_spread();
        push_word(kind, SLOT_W'($urandom_range(0, MAX_OBSTACLES - 1)),
                  coord_like(s), coord_like(s), coord_like(s), coord_like(s));
    endtask

    // hold the sender until every predicted flag has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // count register is only written with the block idle
    task automatic write_wall_limit(input int unsigned n);
        wait_drained();
        repeat (LOAD_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wall count per random phase: full table, saturation, empty and small tables
    function automatic int unsigned phase_limit(int unsigned p);
        case (p)
            0: return MAX_OBSTACLES;
            1: return (1 << CFG_W) - 1;
            2: return 1;
            3: return 0;
            4: return 2;
            5: return 7;
            6: return MAX_OBSTACLES;
            7: return 20;
            8: return 100;
            9: return 3;
            default: return 12;
        endcase
    endfunction

    initial begin : stimulus
        t_word_kind kind;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every query is free, whatever its extent
        write_wall_limit(0);
        push_word(WORD_QUERY, 0, C_MIN, C_MIN, C_MAX, C_MAX);
        push_word(WORD_QUERY, 63, C_MAX, C_MIN, C_MIN, C_MAX);
        push_word(WORD_QUERY, 0, 0, 0, 0, 0);

        // a short wall, a full anti-diagonal, a point wall, and the top slot
        push_word(WORD_LOAD, 0, 0, 0, 10, 0);
        push_word(WORD_LOAD, 1, C_MIN, C_MAX, C_MAX, C_MIN);
        push_word(WORD_LOAD, 2, 5, 5, 5, 5);
        push_word(WORD_LOAD, 63, C_MAX, C_MAX, C_MIN, C_MIN);
        write_wall_limit(3);
        push_word(WORD_QUERY, 5, 5, -5, 5, 5);        // proper crossing
        push_word(WORD_QUERY, 0, 0, 1, 10, 1);        // parallel, clear
        push_word(WORD_QUERY, 1, 8, 0, 20, 0);        // collinear overlap
        push_word(WORD_QUERY, 2, 11, 0, 20, 0);       // collinear but apart
        push_word(WORD_QUERY, 3, 10, 0, 10, 7);       // touches a wall end
        push_word(WORD_QUERY, 4, 3, 0, 3, 0);         // point on a wall
        push_word(WORD_QUERY, 5, 5, 5, 5, 5);         // point on a point wall
        push_word(WORD_QUERY, 6, 4, 4, 4, 4);         // point in free space
        push_word(WORD_QUERY, 7, C_MIN, C_MIN, C_MAX, C_MAX);

        // every slot holds a wall before any larger count is set
        for (int unsigned s = 0; s < MAX_OBSTACLES; s++) begin
            push_word(WORD_LOAD, SLOT_W'(s), coord_like(COORD_GRID), coord_like(COORD_GRID),
                      coord_like(COORD_FULL), coord_like(COORD_FULL));
        end

        for (int unsigned p = 0; p < PHASES; p++) begin
            write_wall_limit(phase_limit(p));
            calm = (p % 4 == 2);
            for (int unsigned i = 0; i < PHASE_WORDS; i++) begin
                // now and then the sender waits for every flag to return
                if ($urandom_range(0, 59) == 0) wait_drained();
                kind = ($urandom_range(0, 99) < 30) ? WORD_LOAD : WORD_QUERY;
                push_random(kind);
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("segment_obstacle_collision_check_test passed");
        end else begin
            $display("segment_obstacle_collision_check_test failed");
        end
        $finish;
    end

    // hung handshake guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("segment_obstacle_collision_check_test failed");
        $finish;
    end

endmodule
